// File: src/rkd_pkg.sv
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared widths, codes and request/response types of the key derivation core.
// ----------------------------------------------------------------------------
package rkd_pkg;

  // width of the prime inputs actually used
  localparam int PRIME_WIDTH = 32;
  // width of a prime field on the channel
  localparam int FIELD_W     = 32;
  // width of the internal arithmetic word
  localparam int WORD_W      = 64;
  // width of the public exponent register
  localparam int EXP_W       = 32;
  // apb address and data widths
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [EXP_W-1:0] RESET_EXP = 32'd65537;

  // register index codes
  localparam logic REG_PUBLIC_EXP = 1'b0;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_DIV      = 2'd0,
    OP_MULMOD   = 2'd1,
    OP_MULMOD32 = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic [WORD_W-1:0] opa;
    logic [WORD_W-1:0] opb;
    logic [WORD_W-1:0] opm;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } arith_rsp_t;

endpackage

// File: src/rkd_in_if.sv
// ----------------------------------------------------------------------------
// rkd_in_if
// Input channel: one word carries the two primes.
// ----------------------------------------------------------------------------
interface rkd_in_if;
  logic                        valid;
  logic                        ready;
  logic [rkd_pkg::FIELD_W-1:0] prime_p;
  logic [rkd_pkg::FIELD_W-1:0] prime_q;

  modport source (output valid, output prime_p, output prime_q, input ready);
  modport sink   (input valid, input prime_p, input prime_q, output ready);
endinterface

// File: src/rkd_out_if.sv
// ----------------------------------------------------------------------------
// rkd_out_if
// Result channel: one word carries the derived key.
// ----------------------------------------------------------------------------
interface rkd_out_if;
  logic                       valid;
  logic                       ready;
  logic [rkd_pkg::WORD_W-1:0] modulus_n;
  logic [rkd_pkg::WORD_W-1:0] private_exp;
  logic [rkd_pkg::EXP_W-1:0]  crt_exp_p;
  logic [rkd_pkg::EXP_W-1:0]  crt_exp_q;
  logic [rkd_pkg::EXP_W-1:0]  crt_coeff;
  logic                       no_inverse;

  modport source (output valid, output modulus_n, output private_exp, output crt_exp_p,
                  output crt_exp_q, output crt_coeff, output no_inverse, input ready);
  modport sink   (input valid, input modulus_n, input private_exp, input crt_exp_p,
                  input crt_exp_q, input crt_coeff, input no_inverse, output ready);
endinterface

// File: src/rkd_cfg.sv
// ----------------------------------------------------------------------------
// rkd_cfg
// APB register slice holding the public exponent.
// ----------------------------------------------------------------------------
module rkd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rkd_pkg::CFG_AW-1:0]  paddr,
  input  logic [rkd_pkg::CFG_DW-1:0]  pwdata,
  output logic [rkd_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [rkd_pkg::EXP_W-1:0]   public_exp
);

  logic [rkd_pkg::EXP_W-1:0] exp_r;
  logic                      reg_idx;

  assign reg_idx    = paddr[rkd_pkg::CFG_AW-1];
  assign pready     = 1'b1;
  assign public_exp = exp_r;

  // register write in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= rkd_pkg::RESET_EXP;
    end else if (psel && penable && pwrite && reg_idx == rkd_pkg::REG_PUBLIC_EXP) begin
      exp_r <= pwdata[rkd_pkg::EXP_W-1:0];
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      rkd_pkg::REG_PUBLIC_EXP: prdata = rkd_pkg::CFG_DW'(exp_r);
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: src/rkd_arith.sv
// ----------------------------------------------------------------------------
// rkd_arith
// Shared bit-serial unit: restoring division and double-and-add mod multiply.
// ----------------------------------------------------------------------------
module rkd_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  rkd_pkg::arith_req_t req,
  output rkd_pkg::arith_rsp_t rsp
);

  localparam logic [6:0] CNT_FULL = 7'd64;
  localparam logic [6:0] CNT_HALF = 7'd32;

  logic                       busy_r;
  logic                       done_r;
  logic                       phase_r;
  logic [6:0]                 cnt_r;
  rkd_pkg::arith_op_t         op_r;
  logic [rkd_pkg::WORD_W-1:0] a_r;
  logic [rkd_pkg::WORD_W-1:0] b_r;
  logic [rkd_pkg::WORD_W-1:0] m_r;
  logic [rkd_pkg::WORD_W-1:0] acc_r;

  logic                       take;
  logic                       last;
  logic [rkd_pkg::WORD_W:0]   dsh;
  logic                       dge;
  logic [rkd_pkg::WORD_W:0]   dsub;
  logic [rkd_pkg::WORD_W-1:0] addend;
  logic [rkd_pkg::WORD_W:0]   sum;
  logic [rkd_pkg::WORD_W:0]   red;
  logic                       step;

  assign take = req.start && !busy_r;
  assign last = (cnt_r == 7'd1);

  // division step: shift in one dividend bit, subtract when it fits
  assign dsh  = {acc_r, b_r[rkd_pkg::WORD_W-1]};
  assign dge  = (dsh >= {1'b0, m_r});
  assign dsub = dsh - {1'b0, m_r};

  // modular add: double in phase 0, add multiplicand in phase 1
  assign addend = phase_r ? a_r : acc_r;
  assign sum    = {1'b0, acc_r} + {1'b0, addend};
  assign red    = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;

  // a multiplier bit is finished after phase 1, or after phase 0 when it is clear
  assign step = phase_r || !b_r[rkd_pkg::WORD_W-1];

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (take) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= (req.op == rkd_pkg::OP_MULMOD32) ? CNT_HALF : CNT_FULL;
      end else if (busy_r) begin
        case (op_r)
          rkd_pkg::OP_DIV: begin
            cnt_r <= cnt_r - 7'd1;
            if (last) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          rkd_pkg::OP_MULMOD, rkd_pkg::OP_MULMOD32: begin
            phase_r <= !step;
            if (step) begin
              cnt_r <= cnt_r - 7'd1;
              if (last) begin
                busy_r <= 1'b0;
                done_r <= 1'b1;
              end
            end
          end
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (take) begin
      op_r  <= req.op;
      a_r   <= req.opa;
      acc_r <= '0;
      case (req.op)
        rkd_pkg::OP_DIV: begin
          b_r <= req.opa;
          m_r <= req.opb;
        end
        rkd_pkg::OP_MULMOD32: begin
          b_r <= {req.opb[rkd_pkg::WORD_W/2-1:0], {(rkd_pkg::WORD_W/2){1'b0}}};
          m_r <= req.opm;
        end
        default: begin
          b_r <= req.opb;
          m_r <= req.opm;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        rkd_pkg::OP_DIV: begin
          acc_r <= dge ? dsub[rkd_pkg::WORD_W-1:0] : dsh[rkd_pkg::WORD_W-1:0];
          b_r   <= {b_r[rkd_pkg::WORD_W-2:0], dge};
        end
        default: begin
          acc_r <= red[rkd_pkg::WORD_W-1:0];
          if (step) begin
            b_r <= {b_r[rkd_pkg::WORD_W-2:0], 1'b0};
          end
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = b_r;
  assign rsp.rem  = acc_r;

endmodule

// File: src/rsa_key_derivation_core.sv
// ----------------------------------------------------------------------------
// rsa_key_derivation_core
// Derives n, d, dp, dq and the crt coefficient from two primes.
//
//   channel  direction  handshake      contents
//   in_ch    in         valid/ready    prime_p, prime_q
//   out_ch   out        valid/ready    modulus_n, private_exp, crt_exp_p/q,
//                                      crt_coeff, no_inverse
//   apb      in         psel/penable   public_exp at address 0
//
// Work is done by the bit-serial arithmetic unit: one division and one 64-bit
// modular multiply per euclid step, then 64-bit crt divisions and up to 64
// 32-bit modular multiplies for the coefficient. A prime p below two skips
// the coefficient work.
// Synchronous active-low reset; public_exp resets to 65537.
// The next word is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
module rsa_key_derivation_core (
  input  logic                       clk,
  input  logic                       rst_n,
  rkd_in_if.sink                     in_ch,
  rkd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rkd_pkg::CFG_AW-1:0] paddr,
  input  logic [rkd_pkg::CFG_DW-1:0] pwdata,
  output logic [rkd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_MUL    = 20'h00002,
    ST_CHK    = 20'h00004,
    ST_EMOD_W = 20'h00008,
    ST_LOOP   = 20'h00010,
    ST_QDIV_W = 20'h00020,
    ST_QMUL_S = 20'h00040,
    ST_QMUL_W = 20'h00080,
    ST_FIX    = 20'h00100,
    ST_CRTP   = 20'h00200,
    ST_CRTP_W = 20'h00400,
    ST_CRTQ   = 20'h00800,
    ST_CRTQ_W = 20'h01000,
    ST_COEF   = 20'h02000,
    ST_COEF_W = 20'h04000,
    ST_PLOOP  = 20'h08000,
    ST_PMR_W  = 20'h10000,
    ST_PSQ    = 20'h20000,
    ST_PSQ_W  = 20'h40000,
    ST_DONE   = 20'h80000
  } state_t;

  localparam int PW = rkd_pkg::PRIME_WIDTH;
  localparam int WW = rkd_pkg::WORD_W;
  localparam int EW = rkd_pkg::EXP_W;

  state_t                    state_r;
  logic [PW-1:0]             p_r, q_r, pm1_r, qm1_r, ex_r;
  logic [WW-1:0]             n_r, phi_r, r0_r, r1_r, t0_r, t1_r, qt_r, d_r;
  logic [WW:0]               tmp_r;
  logic                      fail_r;
  logic [EW-1:0]             dp_r, dq_r, coef_r, base_r;
  logic                      out_valid_r;
  logic [WW-1:0]             o_n_r, o_d_r;
  logic [EW-1:0]             o_dp_r, o_dq_r, o_coef_r;
  logic                      o_fail_r;

  logic [EW-1:0]             public_exp;
  rkd_pkg::arith_req_t       areq;
  rkd_pkg::arith_rsp_t       arsp;
  logic                      in_take;
  logic                      out_free;
  logic [PW-1:0]             p_in, q_in;

  rkd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .public_exp (public_exp)
  );

  rkd_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  assign p_in     = in_ch.prime_p[PW-1:0];
  assign q_in     = in_ch.prime_q[PW-1:0];
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // requests to the shared unit
  always_comb begin
    areq.start = 1'b0;
    areq.op    = rkd_pkg::OP_DIV;
    areq.opa   = '0;
    areq.opb   = '0;
    areq.opm   = '0;
    unique case (state_r)
      ST_CHK: begin
        areq.start = (phi_r != '0);
        areq.opa   = WW'(public_exp);
        areq.opb   = phi_r;
      end
      ST_LOOP: begin
        areq.start = (r1_r != '0);
        areq.opa   = r0_r;
        areq.opb   = r1_r;
      end
      ST_QMUL_S: begin
        areq.start = 1'b1;
        areq.op    = rkd_pkg::OP_MULMOD;
        areq.opa   = qt_r;
        areq.opb   = t1_r;
        areq.opm   = phi_r;
      end
      ST_CRTP: begin
        areq.start = (pm1_r != '0);
        areq.opa   = d_r;
        areq.opb   = WW'(pm1_r);
      end
      ST_CRTQ: begin
        areq.start = (qm1_r != '0);
        areq.opa   = d_r;
        areq.opb   = WW'(qm1_r);
      end
      ST_COEF: begin
        areq.start = (p_r >= PW'(2));
        areq.opa   = WW'(q_r);
        areq.opb   = WW'(p_r);
      end
      ST_PLOOP: begin
        areq.start = (ex_r != '0) && ex_r[0];
        areq.op    = rkd_pkg::OP_MULMOD32;
        areq.opa   = WW'(coef_r);
        areq.opb   = WW'(base_r);
        areq.opm   = WW'(p_r);
      end
      ST_PSQ: begin
        areq.start = 1'b1;
        areq.op    = rkd_pkg::OP_MULMOD32;
        areq.opa   = WW'(base_r);
        areq.opb   = WW'(base_r);
        areq.opm   = WW'(p_r);
      end
      default: begin
        areq.start = 1'b0;
      end
    endcase
  end

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            p_r     <= p_in;
            q_r     <= q_in;
            pm1_r   <= (p_in != '0) ? p_in - PW'(1) : '0;
            qm1_r   <= (q_in != '0) ? q_in - PW'(1) : '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          n_r     <= WW'(p_r) * WW'(q_r);
          phi_r   <= WW'(pm1_r) * WW'(qm1_r);
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (phi_r == '0) begin
            fail_r  <= 1'b1;
            d_r     <= '0;
            state_r <= ST_CRTP;
          end else begin
            state_r <= ST_EMOD_W;
          end
        end
        ST_EMOD_W: begin
          if (arsp.done) begin
            r0_r    <= phi_r;
            r1_r    <= arsp.rem;
            t0_r    <= '0;
            t1_r    <= (phi_r == WW'(1)) ? '0 : WW'(1);
            state_r <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (r1_r == '0) begin
            fail_r  <= (r0_r != WW'(1));
            d_r     <= (r0_r == WW'(1)) ? t0_r : '0;
            state_r <= ST_CRTP;
          end else begin
            state_r <= ST_QDIV_W;
          end
        end
        ST_QDIV_W: begin
          if (arsp.done) begin
            r0_r    <= r1_r;
            r1_r    <= arsp.rem;
            qt_r    <= (arsp.quot == phi_r) ? '0 : arsp.quot;
            state_r <= ST_QMUL_S;
          end
        end
        ST_QMUL_S: begin
          state_r <= ST_QMUL_W;
        end
        ST_QMUL_W: begin
          if (arsp.done) begin
            tmp_r   <= {1'b0, t0_r} - {1'b0, arsp.rem};
            state_r <= ST_FIX;
          end
        end
        ST_FIX: begin
          // lift a negative coefficient by phi
          t0_r    <= t1_r;
          t1_r    <= tmp_r[WW] ? tmp_r[WW-1:0] + phi_r : tmp_r[WW-1:0];
          state_r <= ST_LOOP;
        end
        ST_CRTP: begin
          if (pm1_r == '0) begin
            dp_r    <= '0;
            state_r <= ST_CRTQ;
          end else begin
            state_r <= ST_CRTP_W;
          end
        end
        ST_CRTP_W: begin
          if (arsp.done) begin
            dp_r    <= arsp.rem[EW-1:0];
            state_r <= ST_CRTQ;
          end
        end
        ST_CRTQ: begin
          if (qm1_r == '0) begin
            dq_r    <= '0;
            state_r <= ST_COEF;
          end else begin
            state_r <= ST_CRTQ_W;
          end
        end
        ST_CRTQ_W: begin
          if (arsp.done) begin
            dq_r    <= arsp.rem[EW-1:0];
            state_r <= ST_COEF;
          end
        end
        ST_COEF: begin
          if (p_r < PW'(2)) begin
            coef_r  <= '0;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_COEF_W;
          end
        end
        ST_COEF_W: begin
          if (arsp.done) begin
            base_r  <= arsp.rem[EW-1:0];
            coef_r  <= EW'(1);
            ex_r    <= p_r - PW'(2);
            state_r <= ST_PLOOP;
          end
        end
        ST_PLOOP: begin
          if (ex_r == '0) begin
            state_r <= ST_DONE;
          end else if (ex_r[0]) begin
            state_r <= ST_PMR_W;
          end else begin
            state_r <= ST_PSQ;
          end
        end
        ST_PMR_W: begin
          if (arsp.done) begin
            coef_r  <= arsp.rem[EW-1:0];
            state_r <= ST_PSQ;
          end
        end
        ST_PSQ: begin
          state_r <= ST_PSQ_W;
        end
        ST_PSQ_W: begin
          if (arsp.done) begin
            base_r  <= arsp.rem[EW-1:0];
            ex_r    <= {1'b0, ex_r[PW-1:1]};
            state_r <= ST_PLOOP;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      o_n_r    <= n_r;
      o_d_r    <= d_r;
      o_dp_r   <= dp_r;
      o_dq_r   <= dq_r;
      o_coef_r <= coef_r;
      o_fail_r <= fail_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.modulus_n   = o_n_r;
  assign out_ch.private_exp = o_d_r;
  assign out_ch.crt_exp_p   = o_dp_r;
  assign out_ch.crt_exp_q   = o_dq_r;
  assign out_ch.crt_coeff   = o_coef_r;
  assign out_ch.no_inverse  = o_fail_r;

  // a finished key always lands in the output register
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid_r)
    else $error("finished key not loaded into output register");

  // a failed inverse reports a zero private exponent
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_fail_r) |-> (o_d_r == '0))
    else $error("no_inverse set with nonzero private exponent");

  // a found inverse lies below phi
  a_d_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CRTP && !fail_r) |-> (d_r < phi_r))
    else $error("private exponent not reduced modulo phi");

endmodule
